/* design/htd_pkg.sv */
// Shared types and constants for the Huffman tree decoder.
`timescale 1ns / 1ps

package htd_pkg;

	localparam int SYM_W       = 8;   // decoded byte width
	localparam int COUNT_W     = 32;  // symbol count register width
	localparam int TDATA_W     = 8;   // stream data width on both sides
	localparam int QUEUE_DEPTH = 2;   // entries in each small queue
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LEAF,
		PH_DECODE,
		PH_HALT
	} phase_t;

	// One accepted input bit after classification.
	typedef struct packed {
		logic restart;
		logic code_bit;
	} item_t;

	// One result on its way to the output port.
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_symbol;
		logic             error;
	} result_t;

endpackage

/* design/htd_front.sv */
// Input side: takes stream transactions, classifies them and queues them for the engine.
`timescale 1ns / 1ps

module htd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [htd_pkg::TDATA_W-1:0] s_tdata,
	input  logic                        s_tuser,
	output logic                        q_valid,
	input  logic                        q_pop,
	output htd_pkg::item_t              q_item
);
	import htd_pkg::*;

	item_t             slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	item_t             new_item;

	assign s_tready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign push     = s_tvalid && s_tready;
	assign pop      = q_pop && q_valid;

	// Start flag rides in tuser, the code bit in the lowest data bit.
	always_comb begin
		new_item.restart  = s_tuser;
		new_item.code_bit = s_tdata[0];
	end

	assign q_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

/* design/htd_engine.sv */
// Back end: rebuilds the tree from the header and walks it to decode symbols.
`timescale 1ns / 1ps

module htd_engine #(
	parameter int MAX_NODES   = 511,
	parameter int STACK_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [htd_pkg::COUNT_W-1:0] symbol_total,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  htd_pkg::item_t              in_item,
	output logic                        res_valid,
	output htd_pkg::result_t            res_data,
	input  logic                        out_full
);
	import htd_pkg::*;

	localparam int NIDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NCNT_W  = $clog2(MAX_NODES + 1);
	localparam int PAY_W   = (NIDX_W > SYM_W) ? NIDX_W : SYM_W;
	localparam int CHILD_W = PAY_W + 1;
	localparam int RIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int RCNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int SP_W    = $clog2(STACK_DEPTH + 3);
	localparam int LCNT_W  = $clog2(SYM_W);

	// Child tables: per node, {leaf flag, child index or leaf symbol}.
	logic [CHILD_W-1:0] left_mem  [MAX_NODES];
	logic [CHILD_W-1:0] right_mem [MAX_NODES];
	// Parents whose right slot is still open; the open left slot is flagged by lpend_q, its parent in lpar_q.
	logic [NIDX_W-1:0]  rstack_mem [STACK_DEPTH];

	phase_t             phase_q, phase_d, cur_phase;
	logic [NCNT_W-1:0]  nodes_q, nodes_d, hdr_nodes;
	logic [RCNT_W-1:0]  rcount_q, rcount_d, hdr_rcount;
	logic               lpend_q, lpend_d, hdr_lpend;
	logic [NIDX_W-1:0]  lpar_q, lpar_d;
	logic [NIDX_W-1:0]  leaf_par_q, leaf_par_d;
	logic               leaf_right_q, leaf_right_d;
	logic               leaf_linked_q, leaf_linked_d;
	logic               root_leaf_q, root_leaf_d;
	logic [SYM_W-1:0]   root_sym_q, root_sym_d;
	logic [SYM_W-1:0]   shift_q, shift_d;
	logic [LCNT_W-1:0]  lcnt_q, lcnt_d;
	logic [NIDX_W-1:0]  walk_q, walk_d;
	logic [COUNT_W-1:0] emitted_q, emitted_d, emitted_inc;
	logic [CHILD_W-1:0] left_rd_q, right_rd_q;
	logic [NIDX_W-1:0]  rtop_q;

	logic               fire, restart, code;
	logic [NIDX_W-1:0]  n_idx;
	logic [SP_W-1:0]    sp_cur, sp_after, sp_now;
	logic               node_full, stack_full, hdr_err;
	logic               do_pop, pop_left, pop_right;
	logic [NIDX_W-1:0]  pop_par;
	logic [SYM_W-1:0]   leaf_sym, dec_sym;
	logic               leaf_done, cnt_done, is_last;
	logic [CHILD_W-1:0] child;
	logic               child_leaf;
	logic [PAY_W-1:0]   child_pay;
	logic               dec_emit;
	logic               cw_en, cw_right;
	logic [NIDX_W-1:0]  cw_addr;
	logic [CHILD_W-1:0] cw_data;
	logic               rs_we;
	logic [RIDX_W-1:0]  rs_addr, rs_rd_addr;
	logic [NIDX_W-1:0]  rs_data;

	assign in_ready = !out_full;
	assign fire     = in_valid && !out_full;
	assign restart  = in_item.restart;
	assign code     = in_item.code_bit;

	// A start flag clears the stream state before its own bit is used.
	assign cur_phase  = restart ? PH_HEADER : phase_q;
	assign hdr_nodes  = restart ? '0 : nodes_q;
	assign hdr_rcount = restart ? '0 : rcount_q;
	assign hdr_lpend  = restart ? 1'b0 : lpend_q;
	assign n_idx      = hdr_nodes[NIDX_W-1:0];

	assign sp_cur     = SP_W'(hdr_rcount) + SP_W'(hdr_lpend);
	assign node_full  = (hdr_nodes >= NCNT_W'(MAX_NODES));
	assign do_pop     = (hdr_nodes != '0) && (sp_cur != '0);
	assign pop_left   = do_pop && hdr_lpend;
	assign pop_right  = do_pop && !hdr_lpend;
	assign sp_after   = sp_cur + SP_W'(2) - SP_W'(do_pop);
	assign stack_full = (sp_after > SP_W'(STACK_DEPTH));
	assign hdr_err    = node_full || (!code && stack_full);
	assign pop_par    = pop_left ? lpar_q : rtop_q;

	assign leaf_sym  = {shift_q[SYM_W-2:0], code};
	assign leaf_done = (lcnt_q == LCNT_W'(SYM_W - 1));
	assign sp_now    = SP_W'(rcount_q) + SP_W'(lpend_q);

	assign cnt_done    = (emitted_q >= symbol_total);
	assign emitted_inc = emitted_q + COUNT_W'(1);
	assign is_last     = (emitted_inc == symbol_total);
	assign child       = code ? right_rd_q : left_rd_q;
	assign child_leaf  = child[PAY_W];
	assign child_pay   = child[PAY_W-1:0];
	assign dec_emit    = !cnt_done && (root_leaf_q || child_leaf);
	assign dec_sym     = root_leaf_q ? root_sym_q : child_pay[SYM_W-1:0];

	assign rs_rd_addr = (rcount_q == '0) ? '0 : RIDX_W'(rcount_q - RCNT_W'(1));

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			phase_d = cur_phase;
			case (cur_phase)
				PH_HEADER: begin
					if (hdr_err) begin
						phase_d = PH_HALT;
					end else if (code) begin
						phase_d = PH_LEAF;
					end
				end
				PH_LEAF: begin
					if (leaf_done) begin
						if (sp_now != '0) begin
							phase_d = PH_HEADER;
						end else if (symbol_total == '0) begin
							phase_d = PH_HALT;
						end else begin
							phase_d = PH_DECODE;
						end
					end
				end
				PH_DECODE: begin
					if (cnt_done || (dec_emit && is_last)) begin
						phase_d = PH_HALT;
					end
				end
				PH_HALT: phase_d = PH_HALT;
				default: phase_d = PH_HALT;
			endcase
		end
	end

	// Datapath, table writes and results
	always_comb begin
		nodes_d       = hdr_nodes;
		rcount_d      = hdr_rcount;
		lpend_d       = hdr_lpend;
		lpar_d        = lpar_q;
		leaf_par_d    = leaf_par_q;
		leaf_right_d  = leaf_right_q;
		leaf_linked_d = leaf_linked_q;
		root_leaf_d   = root_leaf_q;
		root_sym_d    = root_sym_q;
		shift_d       = shift_q;
		lcnt_d        = restart ? '0 : lcnt_q;
		walk_d        = restart ? '0 : walk_q;
		emitted_d     = restart ? '0 : emitted_q;
		cw_en         = 1'b0;
		cw_right      = 1'b0;
		cw_addr       = pop_par;
		cw_data       = '0;
		rs_we         = 1'b0;
		rs_addr       = RIDX_W'(hdr_rcount - RCNT_W'(pop_right));
		rs_data       = n_idx;
		res_valid     = 1'b0;
		res_data      = '0;
		if (fire) begin
			case (cur_phase)
				PH_HEADER: begin
					if (hdr_err) begin
						res_valid      = 1'b1;
						res_data.error = 1'b1;
					end else begin
						nodes_d  = hdr_nodes + NCNT_W'(1);
						lcnt_d   = '0;
						rcount_d = hdr_rcount - RCNT_W'(pop_right) + RCNT_W'(!code);
						if (hdr_nodes == '0) begin
							root_leaf_d = code;
						end
						if (pop_left) begin
							lpend_d = 1'b0;
						end
						if (!code) begin
							// Internal node: right slot to the stack, left slot on top.
							lpend_d = 1'b1;
							lpar_d  = n_idx;
							rs_we   = 1'b1;
							if (do_pop) begin
								cw_en    = 1'b1;
								cw_right = pop_right;
								cw_data  = {1'b0, PAY_W'(n_idx)};
							end
						end else begin
							// Leaf: link to the parent once its symbol is complete.
							leaf_linked_d = do_pop;
							leaf_par_d    = pop_par;
							leaf_right_d  = pop_right;
						end
					end
				end
				PH_LEAF: begin
					shift_d = leaf_sym;
					lcnt_d  = lcnt_q + LCNT_W'(1);
					if (leaf_done) begin
						walk_d = '0;
						if (leaf_linked_q) begin
							cw_en    = 1'b1;
							cw_right = leaf_right_q;
							cw_addr  = leaf_par_q;
							cw_data  = {1'b1, PAY_W'(leaf_sym)};
						end else begin
							root_sym_d = leaf_sym;
						end
					end
				end
				PH_DECODE: begin
					if (!cnt_done) begin
						if (dec_emit) begin
							res_valid            = 1'b1;
							res_data.symbol      = dec_sym;
							res_data.last_symbol = is_last;
							emitted_d            = emitted_inc;
							if (!root_leaf_q) begin
								walk_d = '0;
							end
						end else begin
							walk_d = child_pay[NIDX_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Table writes
	always_ff @(posedge clk) begin
		if (cw_en && !cw_right) begin
			left_mem[cw_addr] <= cw_data;
		end
		if (cw_en && cw_right) begin
			right_mem[cw_addr] <= cw_data;
		end
		if (rs_we) begin
			rstack_mem[rs_addr] <= rs_data;
		end
	end

	// Registered reads: children of the next walk node, top of the right-slot stack
	always_ff @(posedge clk) begin
		if (fire) begin
			if (cw_en && !cw_right && (cw_addr == walk_d)) begin
				left_rd_q <= cw_data;
			end else begin
				left_rd_q <= left_mem[walk_d];
			end
			if (cw_en && cw_right && (cw_addr == walk_d)) begin
				right_rd_q <= cw_data;
			end else begin
				right_rd_q <= right_mem[walk_d];
			end
		end
		rtop_q <= rstack_mem[rs_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			lpar_q       <= lpar_d;
			leaf_par_q   <= leaf_par_d;
			leaf_right_q <= leaf_right_d;
			root_sym_q   <= root_sym_d;
			shift_q      <= shift_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			nodes_q       <= '0;
			rcount_q      <= '0;
			lpend_q       <= 1'b0;
			leaf_linked_q <= 1'b0;
			root_leaf_q   <= 1'b0;
			lcnt_q        <= '0;
			walk_q        <= '0;
			emitted_q     <= '0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				nodes_q       <= nodes_d;
				rcount_q      <= rcount_d;
				lpend_q       <= lpend_d;
				leaf_linked_q <= leaf_linked_d;
				root_leaf_q   <= root_leaf_d;
				lcnt_q        <= lcnt_d;
				walk_q        <= walk_d;
				emitted_q     <= emitted_d;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(SP_W'(rcount_q) + SP_W'(lpend_q)) <= SP_W'(STACK_DEPTH))
		else $error("pending slots exceed stack capacity");

	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nodes_q <= NCNT_W'(MAX_NODES))
		else $error("node count exceeds capacity");

	a_err_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.error) |->
		(cur_phase == PH_HEADER && res_data.symbol == '0 && !res_data.last_symbol))
		else $error("error result outside header or with payload");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !restart && phase_q == PH_HALT) |-> !res_valid)
		else $error("result produced while halted");

	a_walk_built: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DECODE) |-> (NCNT_W'(walk_q) < nodes_q))
		else $error("walk node beyond built tree");
`endif

endmodule

/* design/htd_obuf.sv */
// Output side: two-entry result buffer that drives the master stream port.
`timescale 1ns / 1ps

module htd_obuf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	input  htd_pkg::result_t            res_data,
	output logic                        full,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [htd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);
	import htd_pkg::*;

	result_t           slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	result_t           head;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign m_tvalid = (count_q != '0);
	assign push     = res_valid && !full;
	assign pop      = m_tvalid && m_tready;
	assign head     = slots_q[rd_ptr_q];
	assign m_tdata  = TDATA_W'(head.symbol);
	assign m_tlast  = head.last_symbol;
	assign m_tuser  = head.error;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= res_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

endmodule

/* design/huffman_tree_decoder_core.sv */
// Top level of the Huffman tree decoder: input queue, tree engine, output buffer.
`timescale 1ns / 1ps
//
// Channel    Direction  Transaction                 Payload
// s_*        in         one stream bit              tdata[0] code_bit, tuser start_stream
// m_*        out        one decoded symbol / error  tdata[7:0] symbol, tlast last_symbol,
//                                                   tuser error
// cfg_wr_*   in         symbol count write          cfg_wr_data symbol_total
//
// Throughput is one bit per clock while the output buffer is not full. The engine
// keeps the child entries of the current walk node in registers read ahead from the
// node tables, so each bit advances one tree edge or one header step.
// Each bit is registered in the input queue, and its result in the output buffer
// before it raises m_tvalid.
// arst_n clears all control state; the node tables and slot stack are not swept,
// and every entry is written before a complete tree reads it.
// Full output buffer stalls the engine; the input queue keeps taking bits until full.
//
module huffman_tree_decoder_core #(
	parameter int MAX_NODES   = 511,
	parameter int STACK_DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Slave stream: tdata {7'b0, code_bit}; tuser {start_stream}
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [htd_pkg::TDATA_W-1:0] s_tdata,
	input  logic                        s_tuser,
	// Master stream: tdata {symbol}; tuser {error}
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [htd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser,
	// Symbol count register
	input  logic                        cfg_wr_en,
	input  logic [htd_pkg::COUNT_W-1:0] cfg_wr_data
);
	import htd_pkg::*;

	logic [COUNT_W-1:0] symbol_total_q;
	logic               q_valid;
	logic               q_pop;
	item_t              q_item;
	logic               res_valid;
	result_t            res_data;
	logic               out_full;

	// Hold the symbol count; the user must write it only while the decoder is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_total_q <= '0;
		end else if (cfg_wr_en) begin
			symbol_total_q <= cfg_wr_data;
		end
	end

	// Front: accept and queue incoming bits.
	htd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item)
	);

	// Back: tree build and walk, one queued bit per cycle unless the output is full.
	htd_engine #(
		.MAX_NODES   (MAX_NODES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.symbol_total (symbol_total_q),
		.in_valid     (q_valid),
		.in_ready     (q_pop),
		.in_item      (q_item),
		.res_valid    (res_valid),
		.res_data     (res_data),
		.out_full     (out_full)
	);

	// Output buffer decouples the engine from master backpressure.
	htd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_data  (res_data),
		.full      (out_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
